// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame gate checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/core/frlg_pkg.sv
// ----------------------------------------------------------------------------
// frlg_pkg
// Types and constants shared by the frame replay lockdown gate modules
// ----------------------------------------------------------------------------
package frlg_pkg;

    // register file address width (three 32-bit registers)
    localparam int unsigned CFG_AW = 4;

    // register indexes, word address paddr[3:2]
    typedef enum logic [1:0] {
        REG_STREAK_LIMIT  = 2'd0,
        REG_MAX_GAP       = 2'd1,
        REG_HONEYPOT_TYPE = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    // register reset values
    localparam logic [7:0] STREAK_LIMIT_RST  = 8'd3;
    localparam logic [7:0] MAX_GAP_RST       = 8'd16;
    localparam logic [7:0] HONEYPOT_TYPE_RST = 8'd255;

    // frame verdict codes
    typedef enum logic [1:0] {
        V_PASS        = 2'd0,
        V_CRC_DROP    = 2'd1,
        V_REPLAY_DROP = 2'd2,
        V_LOCK_DROP   = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] streak_limit;
        logic [7:0] max_gap;
        logic [7:0] honeypot_type;
    } t_cfg;

    typedef struct packed {
        logic       crc_ok;
        logic [7:0] seq;
        logic [7:0] msg_type;
    } t_frame;

    typedef struct packed {
        t_verdict    verdict;
        logic        lockdown;
        logic [7:0]  invalid_streak_now;
        logic [31:0] ok_count;
        logic [31:0] crc_drop_count;
        logic [31:0] replay_drop_count;
        logic [31:0] honeypot_count;
        logic [7:0]  last_good_type;
        logic [7:0]  last_good_seq;
    } t_result;

endpackage

// File: rtl/core/frame_replay_lockdown_gate.sv
// ----------------------------------------------------------------------------
// frame_replay_lockdown_gate
// Per-frame replay window check with invalid streak lockdown and statistics
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one received frame per
//   transfer: crc flag, sequence number and message type. Output channel
//   (o_out_valid / i_out_stall) returns one result per frame: verdict,
//   lockdown flag, invalid streak and the statistics after that frame.
//   A frame waits in the input register, is checked against the window state
//   and lands in the result register. Throughput is one frame per cycle while
//   the receiver does not stall, set by the single state update per frame
//   between the two registers. Both registers keep moving while the result is
//   taken every cycle; when the receiver stalls, the result holds and a full
//   input register keeps its frame with o_in_stall raised in the same cycle,
//   while an empty one still takes one more frame before o_in_stall rises.
//   Reset clears the window, streak, lockdown and all counters, restores the
//   register defaults (limit 3, gap 16, honeypot type 255) and empties both
//   registers. Lockdown ends only at reset. The user writes registers over the
//   APB port only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module frame_replay_lockdown_gate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frlg_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // frame input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_crc_ok,
    input  logic [7:0]                  i_seq,
    input  logic [7:0]                  i_msg_type,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_verdict,
    output logic                        o_lockdown,
    output logic [7:0]                  o_invalid_streak_now,
    output logic [31:0]                 o_ok_count,
    output logic [31:0]                 o_crc_drop_count,
    output logic [31:0]                 o_replay_drop_count,
    output logic [31:0]                 o_honeypot_count,
    output logic [7:0]                  o_last_good_type,
    output logic [7:0]                  o_last_good_seq
);

    frlg_pkg::t_cfg    cfg;
    frlg_pkg::t_frame  r_frame;
    frlg_pkg::t_result res_next;
    frlg_pkg::t_result r_res;
    logic              r_in_valid,  n_in_valid;
    logic              r_out_valid, n_out_valid;
    logic              adv;
    logic              in_load;

    frlg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    frlg_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_frame (r_frame),
        .i_cfg   (cfg),
        .o_res   (res_next)
    );

    // pipeline handshake
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_load    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_load) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input and result payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_frame.crc_ok   <= i_crc_ok;
            r_frame.seq      <= i_seq;
            r_frame.msg_type <= i_msg_type;
        end
        if (adv) begin
            r_res <= res_next;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_res.verdict;
    assign o_lockdown           = r_res.lockdown;
    assign o_invalid_streak_now = r_res.invalid_streak_now;
    assign o_ok_count           = r_res.ok_count;
    assign o_crc_drop_count     = r_res.crc_drop_count;
    assign o_replay_drop_count  = r_res.replay_drop_count;
    assign o_honeypot_count     = r_res.honeypot_count;
    assign o_last_good_type     = r_res.last_good_type;
    assign o_last_good_seq      = r_res.last_good_seq;

endmodule

// File: rtl/core/frlg_regs.sv
// ----------------------------------------------------------------------------
// frlg_regs
// APB register file holding streak limit, maximum gap and honeypot type
// ----------------------------------------------------------------------------
module frlg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frlg_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output frlg_pkg::t_cfg               o_cfg
);

    logic [7:0]          r_streak_limit;
    logic [7:0]          r_max_gap;
    logic [7:0]          r_honeypot_type;
    frlg_pkg::t_reg_idx  reg_idx;
    logic                wr_en;

    assign reg_idx = frlg_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_limit  <= frlg_pkg::STREAK_LIMIT_RST;
            r_max_gap       <= frlg_pkg::MAX_GAP_RST;
            r_honeypot_type <= frlg_pkg::HONEYPOT_TYPE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                frlg_pkg::REG_STREAK_LIMIT:  r_streak_limit  <= pwdata[7:0];
                frlg_pkg::REG_MAX_GAP:       r_max_gap       <= pwdata[7:0];
                frlg_pkg::REG_HONEYPOT_TYPE: r_honeypot_type <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            frlg_pkg::REG_STREAK_LIMIT:  prdata = {24'd0, r_streak_limit};
            frlg_pkg::REG_MAX_GAP:       prdata = {24'd0, r_max_gap};
            frlg_pkg::REG_HONEYPOT_TYPE: prdata = {24'd0, r_honeypot_type};
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg.streak_limit  = r_streak_limit;
    assign o_cfg.max_gap       = r_max_gap;
    assign o_cfg.honeypot_type = r_honeypot_type;

endmodule

// File: rtl/core/frlg_check.sv
// ----------------------------------------------------------------------------
// frlg_check
// Sequence window check, invalid streak, lockdown and statistics state
// ----------------------------------------------------------------------------
module frlg_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  frlg_pkg::t_frame  i_frame,
    input  frlg_pkg::t_cfg    i_cfg,
    output frlg_pkg::t_result o_res
);

    logic        r_seq_seen,      n_seq_seen;
    logic [7:0]  r_last_seq,      n_last_seq;
    logic [7:0]  r_streak,        n_streak;
    logic        r_locked,        n_locked;
    logic [31:0] r_good_frames,   n_good_frames;
    logic [31:0] r_crc_drops,     n_crc_drops;
    logic [31:0] r_replay_drops,  n_replay_drops;
    logic [31:0] r_honeypot_hits, n_honeypot_hits;
    logic [7:0]  r_last_type,     n_last_type;

    logic [7:0]         seq_step;
    logic               seq_bad;
    logic [7:0]         streak_inc;
    logic               type_hit;
    frlg_pkg::t_verdict verdict;

    // forward step from the last accepted number, modulo 256
    assign seq_step   = i_frame.seq - r_last_seq;
    assign seq_bad    = r_seq_seen && ((seq_step == 8'd0) || (seq_step > i_cfg.max_gap));
    assign streak_inc = (r_streak == 8'hFF) ? r_streak : r_streak + 8'd1;
    assign type_hit   = (i_frame.msg_type == i_cfg.honeypot_type);

    // next state and verdict for the frame in the input register
    always_comb begin
        n_seq_seen      = r_seq_seen;
        n_last_seq      = r_last_seq;
        n_streak        = r_streak;
        n_locked        = r_locked;
        n_good_frames   = r_good_frames;
        n_crc_drops     = r_crc_drops;
        n_replay_drops  = r_replay_drops;
        n_honeypot_hits = r_honeypot_hits;
        n_last_type     = r_last_type;
        verdict         = frlg_pkg::V_PASS;
        if (!i_frame.crc_ok) begin
            n_crc_drops = r_crc_drops + 32'd1;
            n_streak    = streak_inc;
            if (streak_inc >= i_cfg.streak_limit) begin
                n_locked = 1'b1;
            end
            verdict = frlg_pkg::V_CRC_DROP;
        end else if (seq_bad) begin
            n_replay_drops = r_replay_drops + 32'd1;
            n_streak       = streak_inc;
            if (streak_inc >= i_cfg.streak_limit) begin
                n_locked = 1'b1;
            end
            verdict = frlg_pkg::V_REPLAY_DROP;
        end else begin
            n_seq_seen    = 1'b1;
            n_last_seq    = i_frame.seq;
            n_streak      = 8'd0;
            n_good_frames = r_good_frames + 32'd1;
            n_last_type   = i_frame.msg_type;
            if (r_locked && !type_hit) begin
                verdict = frlg_pkg::V_LOCK_DROP;
            end else begin
                verdict = frlg_pkg::V_PASS;
                if (type_hit) begin
                    n_honeypot_hits = r_honeypot_hits + 32'd1;
                end
            end
        end
    end

    // state update when the frame moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_seen      <= 1'b0;
            r_last_seq      <= 8'd0;
            r_streak        <= 8'd0;
            r_locked        <= 1'b0;
            r_good_frames   <= 32'd0;
            r_crc_drops     <= 32'd0;
            r_replay_drops  <= 32'd0;
            r_honeypot_hits <= 32'd0;
            r_last_type     <= 8'd0;
        end else if (i_adv) begin
            r_seq_seen      <= n_seq_seen;
            r_last_seq      <= n_last_seq;
            r_streak        <= n_streak;
            r_locked        <= n_locked;
            r_good_frames   <= n_good_frames;
            r_crc_drops     <= n_crc_drops;
            r_replay_drops  <= n_replay_drops;
            r_honeypot_hits <= n_honeypot_hits;
            r_last_type     <= n_last_type;
        end
    end

    // result fields show the state after this frame
    assign o_res.verdict            = verdict;
    assign o_res.lockdown           = n_locked;
    assign o_res.invalid_streak_now = n_streak;
    assign o_res.ok_count           = n_good_frames;
    assign o_res.crc_drop_count     = n_crc_drops;
    assign o_res.replay_drop_count  = n_replay_drops;
    assign o_res.honeypot_count     = n_honeypot_hits;
    assign o_res.last_good_type     = n_last_type;
    assign o_res.last_good_seq      = n_last_seq;

endmodule

// File: rtl/core/frlg_checker.sv
// ----------------------------------------------------------------------------
// frlg_checker
// Port-level assertions for the frame replay lockdown gate
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frlg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_stall,
    input logic       o_out_valid,
    input logic [1:0] o_verdict,
    input logic       o_lockdown,
    input logic [7:0] o_invalid_streak_now
);

    // reset empties the result register
    `ASSERT_CLK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a lockdown drop is only reported while lockdown is active
    `ASSERT_CLK(a_lock_verdict, i_clk, i_rst_n, (o_out_valid && (o_verdict == frlg_pkg::V_LOCK_DROP)) |-> o_lockdown, "lockdown drop without lockdown")

    // lockdown never clears without reset
    `ASSERT_CLK(a_lock_sticky, i_clk, i_rst_n, ($past(i_rst_n) && $past(o_out_valid && o_lockdown)) |-> o_lockdown, "lockdown cleared")

    // in-window frames clear the streak, also lockdown drops; crc and replay drops leave it nonzero
    `ASSERT_CLK(a_streak, i_clk, i_rst_n, o_out_valid |-> ((o_invalid_streak_now == 8'd0) == ((o_verdict == frlg_pkg::V_PASS) || (o_verdict == frlg_pkg::V_LOCK_DROP))), "streak does not match verdict")

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_verdict)), "stalled result changed")

endmodule

bind frame_replay_lockdown_gate frlg_checker u_frlg_checker (.*);

// File: dv/frame_replay_lockdown_gate_test.sv
// ----------------------------------------------------------------------------
// frame_replay_lockdown_gate_test
// Self-checking bench for the frame replay lockdown gate: a short table of
// frames and register writes, split around random frame streams under several
// window settings, all scored against an in-bench model of the gate
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_replay_lockdown_gate_test;

    localparam int CLK_PERIOD = 4;

    // one directed step: a register write or a frame, optionally with a typed
    // verdict, lockdown flag and streak; rel_seq makes seq a step from the
    // last accepted sequence number
    typedef struct packed {
        bit                   is_write;
        frlg_pkg::t_reg_idx   reg_idx;
        logic [7:0]           reg_val;
        bit                   rel_seq;
        logic                 crc_ok;
        logic [7:0]           seq;
        logic [7:0]           msg_type;
        bit                   typed;
        frlg_pkg::t_verdict   verdict;
        logic                 lockdown;
        logic [7:0]           streak;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [frlg_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_crc_ok = 1'b0;
    logic [7:0]  i_seq = 8'd0;
    logic [7:0]  i_msg_type = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_verdict;
    logic        o_lockdown;
    logic [7:0]  o_invalid_streak_now;
    logic [31:0] o_ok_count;
    logic [31:0] o_crc_drop_count;
    logic [31:0] o_replay_drop_count;
    logic [31:0] o_honeypot_count;
    logic [7:0]  o_last_good_type;
    logic [7:0]  o_last_good_seq;

    // gate model state and register copies
    logic [7:0]  cfg_limit = frlg_pkg::STREAK_LIMIT_RST;
    logic [7:0]  cfg_gap = frlg_pkg::MAX_GAP_RST;
    logic [7:0]  cfg_honey = frlg_pkg::HONEYPOT_TYPE_RST;
    bit          st_seen = 1'b0;
    logic [7:0]  st_last_seq = 8'd0;
    logic [7:0]  st_streak = 8'd0;
    bit          st_locked = 1'b0;
    logic [31:0] cnt_good = '0;
    logic [31:0] cnt_crc = '0;
    logic [31:0] cnt_replay = '0;
    logic [31:0] cnt_honey = '0;
    logic [7:0]  st_last_type = 8'd0;

    frlg_pkg::t_result gate_results_due[$];
    t_row              gate_rows[$];
    frlg_pkg::t_result rx_want;
    int      lock_first;
    int      mismatches = 0;
    int      stall_left = 0;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;

    frame_replay_lockdown_gate u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_crc_ok             (i_crc_ok),
        .i_seq                (i_seq),
        .i_msg_type           (i_msg_type),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_verdict            (o_verdict),
        .o_lockdown           (o_lockdown),
        .o_invalid_streak_now (o_invalid_streak_now),
        .o_ok_count           (o_ok_count),
        .o_crc_drop_count     (o_crc_drop_count),
        .o_replay_drop_count  (o_replay_drop_count),
        .o_honeypot_count     (o_honeypot_count),
        .o_last_good_type     (o_last_good_type),
        .o_last_good_seq      (o_last_good_seq)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // invalid frame: saturating streak, lockdown once the limit is reached
    function automatic void bump_streak();
        if (st_streak != 8'hFF) begin
            st_streak = st_streak + 8'd1;
        end
        if (st_streak >= cfg_limit) begin
            st_locked = 1'b1;
        end
    endfunction

    // verdict and statistics for one frame, advancing the window state
    function automatic frlg_pkg::t_result judge_frame(input logic crc,
                                                      input logic [7:0] sq,
                                                      input logic [7:0] ty);
        frlg_pkg::t_result res;
        logic [7:0]        step;
        bit                in_window;
        step = sq - st_last_seq;
        in_window = !st_seen || (step != 8'd0 && step <= cfg_gap);
        if (!crc) begin
            cnt_crc = cnt_crc + 32'd1;
            bump_streak();
            res.verdict = frlg_pkg::V_CRC_DROP;
        end else if (!in_window) begin
            cnt_replay = cnt_replay + 32'd1;
            bump_streak();
            res.verdict = frlg_pkg::V_REPLAY_DROP;
        end else begin
            st_seen = 1'b1;
            st_last_seq = sq;
            st_streak = 8'd0;
            cnt_good = cnt_good + 32'd1;
            st_last_type = ty;
            if (st_locked && ty != cfg_honey) begin
                res.verdict = frlg_pkg::V_LOCK_DROP;
            end else begin
                res.verdict = frlg_pkg::V_PASS;
                if (ty == cfg_honey) begin
                    cnt_honey = cnt_honey + 32'd1;
                end
            end
        end
        res.lockdown = st_locked;
        res.invalid_streak_now = st_streak;
        res.ok_count = cnt_good;
        res.crc_drop_count = cnt_crc;
        res.replay_drop_count = cnt_replay;
        res.honeypot_count = cnt_honey;
        res.last_good_type = st_last_type;
        res.last_good_seq = st_last_seq;
        return res;
    endfunction

    function automatic t_row write_row(input frlg_pkg::t_reg_idx idx,
                                       input logic [7:0] val);
        t_row r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row frame_row(input bit rel, input logic crc,
                                       input logic [7:0] sq, input logic [7:0] ty);
        t_row r;
        r = '0;
        r.rel_seq = rel;
        r.crc_ok = crc;
        r.seq = sq;
        r.msg_type = ty;
        return r;
    endfunction

    function automatic t_row typed_row(input bit rel, input logic crc,
                                       input logic [7:0] sq, input logic [7:0] ty,
                                       input frlg_pkg::t_verdict v, input logic lk,
                                       input logic [7:0] st);
        t_row r;
        r = frame_row(rel, crc, sq, ty);
        r.typed = 1'b1;
        r.verdict = v;
        r.lockdown = lk;
        r.streak = st;
        return r;
    endfunction

    // random frame: mostly in-window, the rest crc errors, replays and noise
    function automatic t_row random_frame(input bit drops_only);
        t_row r;
        int   kind;
        int   pick;
        r = '0;
        kind = drops_only ? $urandom_range(70, 89) : $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        r.crc_ok = 1'b1;
        r.seq = 8'($urandom_range(0, 255));
        if (pick < 3) begin
            r.msg_type = cfg_honey;
        end else if (pick == 3) begin
            r.msg_type = 8'h00;
        end else if (pick == 4) begin
            r.msg_type = 8'hFF;
        end else begin
            r.msg_type = 8'($urandom_range(0, 255));
        end
        if (kind < 70) begin
            if (cfg_gap != 8'd0) begin
                r.seq = st_last_seq + 8'($urandom_range(1, cfg_gap));
            end
        end else if (kind < 80) begin
            r.crc_ok = 1'b0;
        end else if (kind < 90) begin
            if (cfg_gap == 8'hFF || $urandom_range(0, 2) == 0) begin
                r.seq = st_last_seq;
            end else begin
                r.seq = st_last_seq + 8'($urandom_range(cfg_gap + 1, 255));
            end
        end else begin
            r.crc_ok = 1'($urandom_range(0, 1));
        end
        return r;
    endfunction

    // one frame transfer after a random idle gap, then predict its result
    task automatic send_frame(input t_row r);
        int                idle_cycles;
        frlg_pkg::t_result want;
        idle_cycles = tx_calm ? 0 : $urandom_range(0, 6);
        if (idle_cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle_cycles) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_crc_ok <= r.crc_ok;
        i_seq <= r.seq;
        i_msg_type <= r.msg_type;
        do @(posedge i_clk); while (o_in_stall);
        want = judge_frame(r.crc_ok, r.seq, r.msg_type);
        if (r.typed) begin
            want.verdict = r.verdict;
            want.lockdown = r.lockdown;
            want.invalid_streak_now = r.streak;
        end
        gate_results_due.push_back(want);
        if ($urandom_range(0, 39) == 0) begin
            tx_calm = !tx_calm;
        end
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        while (gate_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input frlg_pkg::t_reg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            frlg_pkg::REG_STREAK_LIMIT:  cfg_limit = val;
            frlg_pkg::REG_MAX_GAP:       cfg_gap = val;
            frlg_pkg::REG_HONEYPOT_TYPE: cfg_honey = val;
            default: ;
        endcase
    endtask

    task automatic play_rows(input int first, input int last);
        t_row r;
        for (int i = first; i <= last; i++) begin
            r = gate_rows[i];
            if (r.is_write) begin
                drain();
                write_reg(r.reg_idx, r.reg_val);
            end else begin
                if (r.rel_seq) begin
                    r.seq = st_last_seq + r.seq;
                end
                send_frame(r);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] limit, input logic [7:0] gap,
                             input logic [7:0] honey, input int n);
        drain();
        write_reg(frlg_pkg::REG_STREAK_LIMIT, limit);
        write_reg(frlg_pkg::REG_MAX_GAP, gap);
        write_reg(frlg_pkg::REG_HONEYPOT_TYPE, honey);
        repeat (n) send_frame(random_frame(1'b0));
    endtask

    // result side: score each transfer, then stall a random number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gate_results_due.size() == 0) begin
                flag_mismatch("result transfer with no frame outstanding");
            end else begin
                rx_want = gate_results_due.pop_front();
                check_field("verdict", o_verdict, rx_want.verdict);
                check_field("lockdown", o_lockdown, rx_want.lockdown);
                check_field("invalid_streak_now", o_invalid_streak_now,
                            rx_want.invalid_streak_now);
                check_field("ok_count", o_ok_count, rx_want.ok_count);
                check_field("crc_drop_count", o_crc_drop_count, rx_want.crc_drop_count);
                check_field("replay_drop_count", o_replay_drop_count,
                            rx_want.replay_drop_count);
                check_field("honeypot_count", o_honeypot_count, rx_want.honeypot_count);
                check_field("last_good_type", o_last_good_type, rx_want.last_good_type);
                check_field("last_good_seq", o_last_good_seq, rx_want.last_good_seq);
            end
            stall_left = rx_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    // main sequence
    initial begin
        // open window, default registers: limit 3, gap 16, honeypot 255
        gate_rows.push_back(typed_row(0, 1'b0, 8'h00, 8'h00, frlg_pkg::V_CRC_DROP,
                                      1'b0, 8'd1));
        gate_rows.push_back(typed_row(0, 1'b1, 8'hFF, 8'hFF, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        gate_rows.push_back(typed_row(0, 1'b1, 8'hFF, 8'h00, frlg_pkg::V_REPLAY_DROP,
                                      1'b0, 8'd1));
        // step of exactly max_gap across the wrap
        gate_rows.push_back(typed_row(0, 1'b1, 8'h0F, 8'h01, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h20, 8'h02, frlg_pkg::V_REPLAY_DROP,
                                      1'b0, 8'd1));
        gate_rows.push_back(typed_row(0, 1'b0, 8'h10, 8'h03, frlg_pkg::V_CRC_DROP,
                                      1'b0, 8'd2));
        gate_rows.push_back(frame_row(0, 1'b1, 8'h10, 8'hFF));
        // widest window: a step of 255 passes
        gate_rows.push_back(write_row(frlg_pkg::REG_STREAK_LIMIT, 8'hFF));
        gate_rows.push_back(write_row(frlg_pkg::REG_MAX_GAP, 8'hFF));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h0F, 8'h80, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        // zero window: every valid frame is a replay
        gate_rows.push_back(write_row(frlg_pkg::REG_MAX_GAP, 8'h00));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h10, 8'h7F, frlg_pkg::V_REPLAY_DROP,
                                      1'b0, 8'd1));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h0F, 8'h00, frlg_pkg::V_REPLAY_DROP,
                                      1'b0, 8'd2));
        // narrowest window that still passes frames
        gate_rows.push_back(write_row(frlg_pkg::REG_MAX_GAP, 8'h01));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h10, 8'h55, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h12, 8'hAA, frlg_pkg::V_REPLAY_DROP,
                                      1'b0, 8'd1));
        gate_rows.push_back(write_row(frlg_pkg::REG_HONEYPOT_TYPE, 8'h00));
        gate_rows.push_back(typed_row(0, 1'b1, 8'h11, 8'h00, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        // lockdown section, played after the first three random phases
        lock_first = gate_rows.size();
        gate_rows.push_back(write_row(frlg_pkg::REG_MAX_GAP, 8'h10));
        gate_rows.push_back(write_row(frlg_pkg::REG_HONEYPOT_TYPE, 8'h5A));
        gate_rows.push_back(write_row(frlg_pkg::REG_STREAK_LIMIT, 8'h00));
        gate_rows.push_back(typed_row(1, 1'b1, 8'd1, 8'h33, frlg_pkg::V_PASS,
                                      1'b0, 8'd0));
        // zero limit: the first drop locks
        gate_rows.push_back(typed_row(0, 1'b0, 8'hAB, 8'h5A, frlg_pkg::V_CRC_DROP,
                                      1'b1, 8'd1));
        gate_rows.push_back(typed_row(1, 1'b1, 8'd2, 8'h33, frlg_pkg::V_LOCK_DROP,
                                      1'b1, 8'd0));
        gate_rows.push_back(typed_row(1, 1'b1, 8'd3, 8'h5A, frlg_pkg::V_PASS,
                                      1'b1, 8'd0));
        gate_rows.push_back(typed_row(1, 1'b1, 8'd0, 8'h5A, frlg_pkg::V_REPLAY_DROP,
                                      1'b1, 8'd1));
        gate_rows.push_back(write_row(frlg_pkg::REG_STREAK_LIMIT, 8'h01));
        gate_rows.push_back(frame_row(1, 1'b1, 8'd16, 8'hFF));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        play_rows(0, lock_first - 1);
        run_phase(8'hFF, 8'hFF, 8'h00, 400);
        run_phase(8'hFF, 8'h01, 8'hFF, 400);
        run_phase(8'd200, 8'($urandom_range(2, 254)), 8'($urandom_range(0, 255)), 400);
        drain();
        play_rows(lock_first, gate_rows.size() - 1);
        // long run of drops: streak saturates
        repeat (300) send_frame(random_frame(1'b1));
        run_phase(8'h01, 8'h10, 8'h00, 150);
        run_phase(8'hFF, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 150);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
